FILE: hdl/dhfk_pkg.sv
// Shared types, constants and arithmetic helpers for the DH kinematics chain.
package dhfk_pkg;

  localparam int JOINT_COUNT_DEF = 6;
  localparam int NUM_REGS        = 6;
  localparam int FULL_TURN       = 23040;
  localparam int HALF_TURN       = 11520;
  localparam int QUARTER_TURN    = 5760;
  localparam int WRAP_TURNS      = 6;
  localparam int ONE_Q14         = 16384;
  localparam int CORDIC_STEPS    = 16;
  localparam int TRIG_LAT        = CORDIC_STEPS + 2;
  localparam int DH_LAT          = 2;
  localparam int POS_MAX         = 524287;
  localparam int POS_MIN         = -524288;
  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [16:0] ang_t;
  typedef logic signed [16:0] tvec_t;
  typedef logic signed [19:0] pos_t;
  typedef logic [63:0]        dh_word_t;
  typedef logic [2:0]         cfg_idx_t;
  typedef q14_t               rot_t [3][3];
  typedef pos_t               pvec_t [3];

  // One joint's DH matrix; the bottom-left entry is always zero.
  typedef struct packed {
    q14_t  m00;
    q14_t  m01;
    q14_t  m02;
    q14_t  m10;
    q14_t  m11;
    q14_t  m12;
    q14_t  m21;
    q14_t  m22;
    tvec_t t0;
    tvec_t t1;
    q14_t  t2;
  } dh_mat_t;

  function automatic logic signed [22:0] atan_val(input logic [3:0] i);
    logic signed [22:0] v;
    case (i)
      4'd0:    v = 23'sd737280;
      4'd1:    v = 23'sd435242;
      4'd2:    v = 23'sd229970;
      4'd3:    v = 23'sd116736;
      4'd4:    v = 23'sd58595;
      4'd5:    v = 23'sd29326;
      4'd6:    v = 23'sd14667;
      4'd7:    v = 23'sd7334;
      4'd8:    v = 23'sd3667;
      4'd9:    v = 23'sd1833;
      4'd10:   v = 23'sd917;
      4'd11:   v = 23'sd458;
      4'd12:   v = 23'sd229;
      4'd13:   v = 23'sd115;
      4'd14:   v = 23'sd57;
      default: v = 23'sd29;
    endcase
    return v;
  endfunction

  // Q2.28 -> Q1.14, round half up (floor shift).
  function automatic logic signed [17:0] rnd14(input logic signed [32:0] v);
    logic signed [32:0] t;
    t = v + 33'sd8192;
    return 18'(t >>> 14);
  endfunction

  function automatic q14_t clamp_q14(input logic signed [17:0] v);
    q14_t r;
    if (v > 18'(ONE_Q14))       r = 16'(ONE_Q14);
    else if (v < 18'(-ONE_Q14)) r = 16'(-ONE_Q14);
    else                        r = 16'(v);
    return r;
  endfunction

endpackage

FILE: hdl/dhfk_cordic.sv
// Pipelined sine/cosine: range fold, one CORDIC step per stage, rounding.
module dhfk_cordic (
  input  logic              clk,
  input  logic              en,
  input  dhfk_pkg::ang_t    ang_i,
  output dhfk_pkg::q14_t    sin_o,
  output dhfk_pkg::q14_t    cos_o
);

  localparam int N = dhfk_pkg::CORDIC_STEPS;

  logic [17:0]        u;
  logic [17:0]        rm;
  logic signed [17:0] r;
  logic signed [17:0] rf;
  logic               neg;

  logic signed [22:0] z_r   [N];
  logic               neg_r [N+1];
  logic signed [32:0] x_r   [N];
  logic signed [32:0] y_r   [N];

  logic signed [32:0] xo;
  logic signed [32:0] yo;
  dhfk_pkg::q14_t     sin_r;
  dhfk_pkg::q14_t     cos_r;

  // Wrap to [-half, half) then fold into [-quarter, quarter].
  always_comb begin
    u  = 18'(ang_i) + 18'(dhfk_pkg::FULL_TURN * 3);
    rm = u;
    for (int m = 1; m < dhfk_pkg::WRAP_TURNS; m++) begin
      if (u >= 18'(m * dhfk_pkg::FULL_TURN)) rm = u - 18'(m * dhfk_pkg::FULL_TURN);
    end
    if (rm >= 18'(dhfk_pkg::HALF_TURN)) r = $signed(rm) - 18'(dhfk_pkg::FULL_TURN);
    else                                r = $signed(rm);
    rf  = r;
    neg = 1'b0;
    if (r > 18'(dhfk_pkg::QUARTER_TURN)) begin
      rf  = r - 18'(dhfk_pkg::HALF_TURN);
      neg = 1'b1;
    end else if (r < 18'(-dhfk_pkg::QUARTER_TURN)) begin
      rf  = r + 18'(dhfk_pkg::HALF_TURN);
      neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]   <= 23'(rf) <<< 8;
      neg_r[0] <= neg;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [32:0] xi;
    logic signed [32:0] yi;
    logic signed [22:0] at;
    if (i == 0) begin : g_first
      assign xi = dhfk_pkg::CORDIC_X0;
      assign yi = '0;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
    end
    assign at = dhfk_pkg::atan_val(4'(i));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][22]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
        end
        neg_r[i+1] <= neg_r[i];
      end
    end

    if (i < N - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) z_r[i+1] <= z_r[i][22] ? z_r[i] + at : z_r[i] - at;
      end
    end else begin : g_zlast
      logic unused_at;
      assign unused_at = ^at;
    end
  end

  assign xo = (x_r[N-1] + 33'sd32768) >>> 16;
  assign yo = (y_r[N-1] + 33'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= neg_r[N] ? -dhfk_pkg::clamp_q14(18'(xo)) : dhfk_pkg::clamp_q14(18'(xo));
      sin_r <= neg_r[N] ? -dhfk_pkg::clamp_q14(18'(yo)) : dhfk_pkg::clamp_q14(18'(yo));
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

FILE: hdl/dhfk_dh_gen.sv
// Builds one joint's DH matrix from sine/cosine pairs, two stages.
module dhfk_dh_gen (
  input  logic              clk,
  input  logic              en,
  input  dhfk_pkg::q14_t    st_i,
  input  dhfk_pkg::q14_t    ct_i,
  input  dhfk_pkg::q14_t    sa_i,
  input  dhfk_pkg::q14_t    ca_i,
  input  logic signed [15:0] len_i,
  input  logic signed [15:0] dz_i,
  output dhfk_pkg::dh_mat_t mat_o
);

  logic signed [29:0] stca_r, stsa_r, ctca_r, ctsa_r;
  logic signed [30:0] lc_r, ls_r;
  dhfk_pkg::q14_t     st_r, ct_r, sa_r, ca_r;
  dhfk_pkg::dh_mat_t  mat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      stca_r <= 30'(32'(st_i) * 32'(ca_i));
      stsa_r <= 30'(32'(st_i) * 32'(sa_i));
      ctca_r <= 30'(32'(ct_i) * 32'(ca_i));
      ctsa_r <= 30'(32'(ct_i) * 32'(sa_i));
      lc_r   <= 31'(32'(len_i) * 32'(ct_i));
      ls_r   <= 31'(32'(len_i) * 32'(st_i));
      st_r   <= st_i;
      ct_r   <= ct_i;
      sa_r   <= sa_i;
      ca_r   <= ca_i;
    end
  end

  // Negation comes after rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      mat_r.m00 <= ct_r;
      mat_r.m01 <= -16'(dhfk_pkg::rnd14(33'(stca_r)));
      mat_r.m02 <= 16'(dhfk_pkg::rnd14(33'(stsa_r)));
      mat_r.m10 <= st_r;
      mat_r.m11 <= 16'(dhfk_pkg::rnd14(33'(ctca_r)));
      mat_r.m12 <= -16'(dhfk_pkg::rnd14(33'(ctsa_r)));
      mat_r.m21 <= sa_r;
      mat_r.m22 <= ca_r;
      mat_r.t0  <= 17'(dhfk_pkg::rnd14(33'(lc_r)));
      mat_r.t1  <= 17'(dhfk_pkg::rnd14(33'(ls_r)));
      mat_r.t2  <= dz_i;
    end
  end

  assign mat_o = mat_r;

endmodule

FILE: hdl/dhfk_joint_cell.sv
// One joint of the chain: R*M and R*t products, then sum, round, clamp.
module dhfk_joint_cell (
  input  logic              clk,
  input  logic              en,
  input  dhfk_pkg::rot_t    rot_i,
  input  dhfk_pkg::pvec_t   pos_i,
  input  dhfk_pkg::dh_mat_t mat_i,
  output dhfk_pkg::rot_t    rot_o,
  output dhfk_pkg::pvec_t   pos_o
);

  dhfk_pkg::q14_t     m  [3][3];
  logic signed [16:0] tv [3];

  logic signed [29:0] prod_r [3][3][3];
  logic signed [30:0] tp_r   [3][3];
  dhfk_pkg::pos_t     posd_r [3];

  dhfk_pkg::rot_t     rot_nxt;
  dhfk_pkg::pvec_t    pos_nxt;
  dhfk_pkg::rot_t     rot_r;
  dhfk_pkg::pvec_t    pos_r;

  always_comb begin
    m[0][0] = mat_i.m00; m[0][1] = mat_i.m01; m[0][2] = mat_i.m02;
    m[1][0] = mat_i.m10; m[1][1] = mat_i.m11; m[1][2] = mat_i.m12;
    m[2][0] = '0;        m[2][1] = mat_i.m21; m[2][2] = mat_i.m22;
    tv[0] = mat_i.t0;
    tv[1] = mat_i.t1;
    tv[2] = 17'(mat_i.t2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        posd_r[r] <= pos_i[r];
        for (int k = 0; k < 3; k++) begin
          tp_r[r][k] <= 31'(33'(rot_i[r][k]) * 33'(tv[k]));
          for (int c = 0; c < 3; c++)
            prod_r[r][c][k] <= 30'(32'(rot_i[r][k]) * 32'(m[k][c]));
        end
      end
    end
  end

  always_comb begin
    logic signed [32:0] acc;
    logic signed [17:0] rn;
    logic signed [20:0] ps;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc = 33'(prod_r[r][c][0]) + 33'(prod_r[r][c][1]) + 33'(prod_r[r][c][2]);
        rot_nxt[r][c] = dhfk_pkg::clamp_q14(dhfk_pkg::rnd14(acc));
      end
      acc = 33'(tp_r[r][0]) + 33'(tp_r[r][1]) + 33'(tp_r[r][2]);
      rn  = dhfk_pkg::rnd14(acc);
      ps  = 21'(posd_r[r]) + 21'(rn);
      if (ps > 21'(dhfk_pkg::POS_MAX))      pos_nxt[r] = 20'(dhfk_pkg::POS_MAX);
      else if (ps < 21'(dhfk_pkg::POS_MIN)) pos_nxt[r] = 20'(dhfk_pkg::POS_MIN);
      else                                  pos_nxt[r] = 20'(ps);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
      pos_r <= pos_nxt;
    end
  end

  assign rot_o = rot_r;
  assign pos_o = pos_r;

endmodule

FILE: hdl/dh_forward_kinematics_chain.sv
// Top level: six-joint DH forward kinematics as a pipelined chain of joint cells.
//
//  channel | ports                                   | direction | handshake
//  --------+-----------------------------------------+-----------+------------------
//  input   | in_joint1_angle .. in_joint6_angle      | in        | in_valid/in_stall
//  result  | out_rot_00 .. out_rot_22, out_pos_x/y/z | out       | out_valid/out_stall
//  config  | cfg_index, cfg_data                     | in        | cfg_we
//
// One item per cycle sustained while no held result blocks the last cell. A result
// passes through the CORDIC pipelines (fold, 16 steps, round), the DH matrix build,
// each joint cell (product stage, sum/round stage) and the output register.
// All joints' sine/cosine run side by side; each joint's matrix is delayed to meet
// its cell in the chain. Reset (rst_n low, synchronous) clears the DH words and the
// valid line; there is no clearing pass. The pipe moves as one; it stops only when
// a result waits in the output register under stall and another reaches the last
// cell, so bubbles still let new items in while a result is held.
module dh_forward_kinematics_chain #(
  parameter int JOINT_COUNT = dhfk_pkg::JOINT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_joint1_angle,
  input  logic signed [15:0] in_joint2_angle,
  input  logic signed [15:0] in_joint3_angle,
  input  logic signed [15:0] in_joint4_angle,
  input  logic signed [15:0] in_joint5_angle,
  input  logic signed [15:0] in_joint6_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_rot_00,
  output logic signed [15:0] out_rot_01,
  output logic signed [15:0] out_rot_02,
  output logic signed [15:0] out_rot_10,
  output logic signed [15:0] out_rot_11,
  output logic signed [15:0] out_rot_12,
  output logic signed [15:0] out_rot_20,
  output logic signed [15:0] out_rot_21,
  output logic signed [15:0] out_rot_22,
  output logic signed [19:0] out_pos_x,
  output logic signed [19:0] out_pos_y,
  output logic signed [19:0] out_pos_z,
  input  logic               cfg_we,
  input  dhfk_pkg::cfg_idx_t cfg_index,
  input  dhfk_pkg::dh_word_t cfg_data
);

  localparam int LAT = dhfk_pkg::TRIG_LAT + dhfk_pkg::DH_LAT + 2 * JOINT_COUNT;

  dhfk_pkg::dh_word_t cfg_r [dhfk_pkg::NUM_REGS];
  logic signed [15:0] ang   [dhfk_pkg::NUM_REGS];

  logic               vld_r [LAT];
  logic               en;
  logic               out_free;
  logic               out_valid_r;
  dhfk_pkg::rot_t     out_rot_r;
  dhfk_pkg::pvec_t    out_pos_r;

  dhfk_pkg::rot_t     rot_c [JOINT_COUNT+1];
  dhfk_pkg::pvec_t    pos_c [JOINT_COUNT+1];

  assign ang[0] = in_joint1_angle;
  assign ang[1] = in_joint2_angle;
  assign ang[2] = in_joint3_angle;
  assign ang[3] = in_joint4_angle;
  assign ang[4] = in_joint5_angle;
  assign ang[5] = in_joint6_angle;

  // Writes past the last DH word are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dhfk_pkg::NUM_REGS; i++) cfg_r[i] <= '0;
    end else if (cfg_we && (cfg_index < 3'(dhfk_pkg::NUM_REGS))) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // Whole pipe advances together unless the last cell would overrun a held result.
  assign out_free = !out_valid_r || !out_stall;
  assign en       = out_free || !vld_r[LAT-1];
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r[0] <= in_valid;
        for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
      end
      if (out_free) out_valid_r <= vld_r[LAT-1];
    end
  end

  // Start of chain: identity rotation, zero position.
  for (genvar r = 0; r < 3; r++) begin : g_id
    for (genvar c = 0; c < 3; c++) begin : g_idc
      assign rot_c[0][r][c] = (r == c) ? 16'(dhfk_pkg::ONE_Q14) : '0;
    end
    assign pos_c[0][r] = '0;
  end

  for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_joint
    dhfk_pkg::ang_t    theta;
    dhfk_pkg::ang_t    twist;
    dhfk_pkg::q14_t    st, ct, sa, ca;
    dhfk_pkg::dh_mat_t mat;
    dhfk_pkg::dh_mat_t mat_d;

    assign theta = 17'(ang[j]) + 17'($signed(cfg_r[j][63:48]));
    assign twist = 17'($signed(cfg_r[j][31:16]));

    dhfk_cordic u_theta (
      .clk   (clk),
      .en    (en),
      .ang_i (theta),
      .sin_o (st),
      .cos_o (ct)
    );

    dhfk_cordic u_twist (
      .clk   (clk),
      .en    (en),
      .ang_i (twist),
      .sin_o (sa),
      .cos_o (ca)
    );

    dhfk_dh_gen u_dh (
      .clk   (clk),
      .en    (en),
      .st_i  (st),
      .ct_i  (ct),
      .sa_i  (sa),
      .ca_i  (ca),
      .len_i ($signed(cfg_r[j][15:0])),
      .dz_i  ($signed(cfg_r[j][47:32])),
      .mat_o (mat)
    );

    // Joint j's matrix runs through a shift register sized by the number of earlier cells.
    if (j == 0) begin : g_nodly
      assign mat_d = mat;
    end else begin : g_dly
      dhfk_pkg::dh_mat_t dl_r [2*j];
      always_ff @(posedge clk) begin
        if (en) begin
          dl_r[0] <= mat;
          for (int k = 1; k < 2 * j; k++) dl_r[k] <= dl_r[k-1];
        end
      end
      assign mat_d = dl_r[2*j-1];
    end

    dhfk_joint_cell u_cell (
      .clk   (clk),
      .en    (en),
      .rot_i (rot_c[j]),
      .pos_i (pos_c[j]),
      .mat_i (mat_d),
      .rot_o (rot_c[j+1]),
      .pos_o (pos_c[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_rot_r <= rot_c[JOINT_COUNT];
      out_pos_r <= pos_c[JOINT_COUNT];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_rot_00 = out_rot_r[0][0];
  assign out_rot_01 = out_rot_r[0][1];
  assign out_rot_02 = out_rot_r[0][2];
  assign out_rot_10 = out_rot_r[1][0];
  assign out_rot_11 = out_rot_r[1][1];
  assign out_rot_12 = out_rot_r[1][2];
  assign out_rot_20 = out_rot_r[2][0];
  assign out_rot_21 = out_rot_r[2][1];
  assign out_rot_22 = out_rot_r[2][2];
  assign out_pos_x  = out_pos_r[0];
  assign out_pos_y  = out_pos_r[1];
  assign out_pos_z  = out_pos_r[2];

endmodule

FILE: hdl/dhfk_checker.sv
// Port-level assertions for the DH kinematics chain, bound to the top level.
module dhfk_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_rot_00,
  input logic signed [15:0] out_rot_11,
  input logic signed [15:0] out_rot_22,
  input logic signed [19:0] out_pos_x
);

  // Input only backs up behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_rot_00) && $stable(out_pos_x)))
    else $error("result changed under stall");

  // Diagonal entries stay inside the Q1.14 unit range.
  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rot_00 >= -16'sd16384 && out_rot_00 <= 16'sd16384 &&
                   out_rot_11 >= -16'sd16384 && out_rot_11 <= 16'sd16384 &&
                   out_rot_22 >= -16'sd16384 && out_rot_22 <= 16'sd16384))
    else $error("rotation entry out of range");

endmodule

bind dh_forward_kinematics_chain dhfk_checker u_dhfk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_rot_00 (out_rot_00),
  .out_rot_11 (out_rot_11),
  .out_rot_22 (out_rot_22),
  .out_pos_x  (out_pos_x)
);
